FILE: sv/paper_feed_motor_controller_assert.svh
// Assertion macros shared by the paper feed motor controller modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef PAPER_FEED_MOTOR_CONTROLLER_ASSERT_SVH
`define PAPER_FEED_MOTOR_CONTROLLER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PFMC_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("pfmc check failed in the same cycle");

// The condition must hold in the cycle after the trigger.
`define PFMC_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("pfmc check failed one cycle later");

`endif

FILE: sv/pfmc_pkg.sv
// Types and constants of the paper feed motor controller.
// Used by pfmc_core and by the top level; depends on nothing.
`default_nettype none

package pfmc_pkg;

   typedef struct packed {
      logic load_sensor;
      logic unload_sensor;
   } req_type;

   typedef struct packed {
      logic load_motor_on;
      logic unload_motor_on;
      logic load_led_toggle;
      logic unload_led_toggle;
      logic no_paper;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pre_motor_delay;
      logic [15:0] load_run_time;
      logic [15:0] unload_run_time;
      logic [15:0] unload_watch_time;
      logic [15:0] unload_pause_time;
      logic [3:0]  sample_window;
      logic [3:0]  sample_threshold;
      logic [7:0]  retry_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      LS_IDLE  = 3'd0,
      LS_ARM   = 3'd1,
      LS_WAIT  = 3'd2,
      LS_CHECK = 3'd3,
      LS_DONE  = 3'd4
   } load_state_type;

   typedef enum logic [2:0] {
      US_IDLE  = 3'd0,
      US_ARM   = 3'd1,
      US_PRE   = 3'd2,
      US_PAUSE = 3'd3,
      US_START = 3'd4,
      US_RUN   = 3'd5,
      US_CHECK = 3'd6,
      US_DONE  = 3'd7
   } unload_state_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_PRE_MOTOR_DELAY   = 3'd0;
   localparam logic [2:0] REG_LOAD_RUN_TIME     = 3'd1;
   localparam logic [2:0] REG_UNLOAD_RUN_TIME   = 3'd2;
   localparam logic [2:0] REG_UNLOAD_WATCH_TIME = 3'd3;
   localparam logic [2:0] REG_UNLOAD_PAUSE_TIME = 3'd4;
   localparam logic [2:0] REG_SAMPLE_WINDOW     = 3'd5;
   localparam logic [2:0] REG_SAMPLE_THRESHOLD  = 3'd6;
   localparam logic [2:0] REG_RETRY_LIMIT       = 3'd7;

   localparam cfg_type CFG_RESET = '{
      pre_motor_delay:   16'd300,
      load_run_time:     16'd10,
      unload_run_time:   16'd20,
      unload_watch_time: 16'd100,
      unload_pause_time: 16'd1,
      sample_window:     4'd10,
      sample_threshold:  4'd9,
      retry_limit:       8'd1
   };

   localparam logic [3:0] HITS_MAX = 4'd15;

endpackage

`default_nettype wire

FILE: sv/paper_feed_motor_controller.sv
// Paper feed motor controller: one tick item in, one result item out.
// An accepted item waits in the input register; its result is registered when that register advances.
// Throughput: one item per cycle while the result side does not stall; the core updates all tick state in one pass.
// Reset clears the sequencers, timers, latches and handshake state and loads
// the configuration registers with their default values.
`default_nettype none

module paper_feed_motor_controller #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pfmc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pfmc_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   `include "paper_feed_motor_controller_assert.svh"

   pfmc_pkg::cfg_type cfg_ff, cfg_in;
   logic              s1_valid_ff, s1_valid_in;
   pfmc_pkg::req_type s1_data_ff;
   logic              out_valid_ff, out_valid_in;
   pfmc_pkg::rsp_type out_data_ff;
   pfmc_pkg::rsp_type core_result;
   logic              out_free, advance, accept, cfg_write;
   logic [2:0]        reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            pfmc_pkg::REG_PRE_MOTOR_DELAY:   cfg_in.pre_motor_delay   = pwdata[15:0];
            pfmc_pkg::REG_LOAD_RUN_TIME:     cfg_in.load_run_time     = pwdata[15:0];
            pfmc_pkg::REG_UNLOAD_RUN_TIME:   cfg_in.unload_run_time   = pwdata[15:0];
            pfmc_pkg::REG_UNLOAD_WATCH_TIME: cfg_in.unload_watch_time = pwdata[15:0];
            pfmc_pkg::REG_UNLOAD_PAUSE_TIME: cfg_in.unload_pause_time = pwdata[15:0];
            pfmc_pkg::REG_SAMPLE_WINDOW:     cfg_in.sample_window     = pwdata[3:0];
            pfmc_pkg::REG_SAMPLE_THRESHOLD:  cfg_in.sample_threshold  = pwdata[3:0];
            pfmc_pkg::REG_RETRY_LIMIT:       cfg_in.retry_limit       = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         pfmc_pkg::REG_PRE_MOTOR_DELAY:   prdata = 32'(cfg_ff.pre_motor_delay);
         pfmc_pkg::REG_LOAD_RUN_TIME:     prdata = 32'(cfg_ff.load_run_time);
         pfmc_pkg::REG_UNLOAD_RUN_TIME:   prdata = 32'(cfg_ff.unload_run_time);
         pfmc_pkg::REG_UNLOAD_WATCH_TIME: prdata = 32'(cfg_ff.unload_watch_time);
         pfmc_pkg::REG_UNLOAD_PAUSE_TIME: prdata = 32'(cfg_ff.unload_pause_time);
         pfmc_pkg::REG_SAMPLE_WINDOW:     prdata = 32'(cfg_ff.sample_window);
         pfmc_pkg::REG_SAMPLE_THRESHOLD:  prdata = 32'(cfg_ff.sample_threshold);
         pfmc_pkg::REG_RETRY_LIMIT:       prdata = 32'(cfg_ff.retry_limit);
         default:                         prdata = 32'd0;
      endcase
   end

   // The input register moves on whenever the result register is empty or
   // being emptied, so a result that is being taken never blocks the next item.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= pfmc_pkg::CFG_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   pfmc_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_data_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `PFMC_ASSERT_SAME(a_no_overwrite, clock, reset,
      s1_valid_ff && out_valid_ff && rsp_stall, req_stall && !advance)
   `PFMC_ASSERT_NEXT(a_accept_fills_stage, clock, reset,
      accept, s1_valid_ff)
   `PFMC_ASSERT_NEXT(a_advance_fills_output, clock, reset,
      advance, rsp_valid)

endmodule

`default_nettype wire

FILE: sv/pfmc_core.sv
// Per-tick state update of the paper feed motor controller: sampling window,
// timers, motor latches and the load and unload sequencers. Uses pfmc_pkg.
`default_nettype none

module pfmc_core #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire pfmc_pkg::req_type item,
   input  wire pfmc_pkg::cfg_type cfg,
   output pfmc_pkg::rsp_type     result
);

   `include "paper_feed_motor_controller_assert.svh"

   localparam int LW = 18;
   localparam int CW = TIMER_WIDTH + LW;
   localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

   // Loads into a timer clip at the largest value the timer holds.
   function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [LW-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      if (ext > CW'(TMAX)) begin
         return TMAX;
      end
      return TIMER_WIDTH'(v);
   endfunction

   logic [3:0]             window_left_ff, window_left_in, window_left_dec;
   logic [3:0]             load_hits_ff, load_hits_in, load_hits_new;
   logic [3:0]             unload_hits_ff, unload_hits_in, unload_hits_new;
   logic [TIMER_WIDTH-1:0] load_pre_ff, load_pre_in, load_pre_dec;
   logic [TIMER_WIDTH-1:0] unload_pre_ff, unload_pre_in, unload_pre_dec;
   logic [TIMER_WIDTH-1:0] load_run_ff, load_run_in, load_run_dec;
   logic [TIMER_WIDTH-1:0] unload_run_ff, unload_run_in, unload_run_dec;
   logic [TIMER_WIDTH-1:0] watch_ff, watch_in, watch_dec;
   pfmc_pkg::load_state_type   load_state_ff, load_state_in;
   pfmc_pkg::unload_state_type unload_state_ff, unload_state_in;
   logic                   paper_missing_ff, paper_missing_in;
   logic [7:0]             retry_ff, retry_in, retry_inc;
   logic                   load_latch_ff, load_latch_in;
   logic                   unload_latch_ff, unload_latch_in;
   logic                   win_close, load_req, unload_req;
   logic                   load_led, unload_led;

   // Sampling happens only while the window is still open.
   assign window_left_dec = (window_left_ff != 4'd0) ? window_left_ff - 4'd1 : 4'd0;
   assign load_hits_new = (window_left_ff != 4'd0 && item.load_sensor &&
                           load_hits_ff != pfmc_pkg::HITS_MAX) ?
                          load_hits_ff + 4'd1 : load_hits_ff;
   assign unload_hits_new = (window_left_ff != 4'd0 && !item.unload_sensor &&
                             unload_hits_ff != pfmc_pkg::HITS_MAX) ?
                            unload_hits_ff + 4'd1 : unload_hits_ff;
   assign win_close  = (window_left_dec == 4'd0);
   assign load_req   = (load_hits_new >= cfg.sample_threshold);
   assign unload_req = (unload_hits_new >= cfg.sample_threshold);

   assign load_pre_dec   = (load_pre_ff != '0) ?
                           load_pre_ff - TIMER_WIDTH'(1) : load_pre_ff;
   assign unload_pre_dec = (unload_pre_ff != '0) ?
                           unload_pre_ff - TIMER_WIDTH'(1) : unload_pre_ff;
   assign load_run_dec   = (load_run_ff != '0) ?
                           load_run_ff - TIMER_WIDTH'(1) : load_run_ff;
   assign unload_run_dec = (unload_run_ff != '0) ?
                           unload_run_ff - TIMER_WIDTH'(1) : unload_run_ff;
   assign watch_dec      = (watch_ff != '0) ? watch_ff - TIMER_WIDTH'(1) : watch_ff;
   assign retry_inc      = retry_ff + 8'd1;

   always_comb begin
      window_left_in   = window_left_dec;
      load_hits_in     = load_hits_new;
      unload_hits_in   = unload_hits_new;
      load_pre_in      = load_pre_dec;
      unload_pre_in    = unload_pre_dec;
      load_run_in      = load_run_dec;
      unload_run_in    = unload_run_dec;
      watch_in         = watch_dec;
      load_state_in    = load_state_ff;
      unload_state_in  = unload_state_ff;
      paper_missing_in = paper_missing_ff;
      retry_in         = retry_ff;
      load_latch_in    = load_latch_ff;
      unload_latch_in  = unload_latch_ff;
      load_led         = 1'b0;
      unload_led       = 1'b0;

      // A running timer turns its motor on near the top and off near the end.
      if (load_run_ff != '0) begin
         if (CW'(load_run_dec) >= CW'(cfg.load_run_time)) begin
            load_latch_in = 1'b1;
         end else if (load_run_dec <= TIMER_WIDTH'(1)) begin
            load_latch_in = 1'b0;
         end
      end
      if (unload_run_ff != '0) begin
         if (CW'(unload_run_dec) >= CW'(cfg.unload_run_time)) begin
            unload_latch_in = 1'b1;
         end else if (unload_run_dec <= TIMER_WIDTH'(1)) begin
            unload_latch_in = 1'b0;
         end
      end

      if (win_close) begin
         load_hits_in   = 4'd0;
         unload_hits_in = 4'd0;
         window_left_in = cfg.sample_window;

         case (load_state_ff)
            pfmc_pkg::LS_IDLE: begin
               load_state_in = load_req ? pfmc_pkg::LS_ARM : pfmc_pkg::LS_DONE;
            end
            pfmc_pkg::LS_ARM: begin
               load_pre_in   = sat_load(LW'(cfg.pre_motor_delay));
               load_state_in = pfmc_pkg::LS_WAIT;
            end
            pfmc_pkg::LS_WAIT: begin
               if (load_pre_dec == '0) begin
                  load_run_in   = sat_load(LW'(cfg.load_run_time) + LW'(1));
                  load_led      = 1'b1;
                  load_state_in = pfmc_pkg::LS_CHECK;
               end
            end
            pfmc_pkg::LS_CHECK: begin
               load_state_in = load_req ? pfmc_pkg::LS_WAIT : pfmc_pkg::LS_DONE;
            end
            default: begin
               load_state_in = pfmc_pkg::LS_IDLE;
            end
         endcase

         case (unload_state_ff)
            pfmc_pkg::US_IDLE: begin
               if (unload_req) begin
                  unload_state_in = pfmc_pkg::US_ARM;
               end else begin
                  paper_missing_in = 1'b0;
                  unload_state_in  = pfmc_pkg::US_DONE;
               end
            end
            pfmc_pkg::US_ARM: begin
               if (!paper_missing_ff) begin
                  unload_pre_in   = sat_load(LW'(cfg.pre_motor_delay));
                  unload_state_in = pfmc_pkg::US_PRE;
               end else begin
                  unload_state_in = pfmc_pkg::US_DONE;
               end
            end
            pfmc_pkg::US_PRE: begin
               if (unload_pre_dec == '0) begin
                  watch_in        = sat_load(LW'(cfg.unload_watch_time));
                  unload_state_in = pfmc_pkg::US_START;
               end
            end
            pfmc_pkg::US_PAUSE: begin
               unload_pre_in   = sat_load(LW'(cfg.unload_pause_time));
               unload_state_in = pfmc_pkg::US_START;
            end
            pfmc_pkg::US_START: begin
               if (unload_pre_dec == '0) begin
                  unload_run_in   = sat_load(LW'(cfg.unload_run_time) + LW'(2));
                  unload_led      = 1'b1;
                  unload_state_in = pfmc_pkg::US_RUN;
               end
            end
            pfmc_pkg::US_RUN: begin
               if (unload_run_dec == '0) begin
                  unload_state_in = pfmc_pkg::US_CHECK;
               end
            end
            pfmc_pkg::US_CHECK: begin
               if (!unload_req) begin
                  unload_state_in = pfmc_pkg::US_DONE;
               end else if (watch_dec == '0) begin
                  // The watch ran out with paper still missing.
                  paper_missing_in = 1'b1;
                  if (retry_inc >= cfg.retry_limit) begin
                     retry_in        = 8'd0;
                     unload_state_in = pfmc_pkg::US_DONE;
                  end else begin
                     retry_in        = retry_inc;
                     unload_state_in = pfmc_pkg::US_PAUSE;
                  end
               end else begin
                  unload_state_in = pfmc_pkg::US_PAUSE;
               end
            end
            default: begin
               unload_state_in = pfmc_pkg::US_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff   <= pfmc_pkg::CFG_RESET.sample_window;
         load_hits_ff     <= 4'd0;
         unload_hits_ff   <= 4'd0;
         load_pre_ff      <= '0;
         unload_pre_ff    <= '0;
         load_run_ff      <= '0;
         unload_run_ff    <= '0;
         watch_ff         <= '0;
         load_state_ff    <= pfmc_pkg::LS_IDLE;
         unload_state_ff  <= pfmc_pkg::US_IDLE;
         paper_missing_ff <= 1'b0;
         retry_ff         <= 8'd0;
         load_latch_ff    <= 1'b0;
         unload_latch_ff  <= 1'b0;
      end else if (step) begin
         window_left_ff   <= window_left_in;
         load_hits_ff     <= load_hits_in;
         unload_hits_ff   <= unload_hits_in;
         load_pre_ff      <= load_pre_in;
         unload_pre_ff    <= unload_pre_in;
         load_run_ff      <= load_run_in;
         unload_run_ff    <= unload_run_in;
         watch_ff         <= watch_in;
         load_state_ff    <= load_state_in;
         unload_state_ff  <= unload_state_in;
         paper_missing_ff <= paper_missing_in;
         retry_ff         <= retry_in;
         load_latch_ff    <= load_latch_in;
         unload_latch_ff  <= unload_latch_in;
      end
   end

   assign result.load_motor_on     = load_latch_in;
   assign result.unload_motor_on   = unload_latch_in;
   assign result.load_led_toggle   = load_led;
   assign result.unload_led_toggle = unload_led;
   assign result.no_paper          = paper_missing_in;

   `PFMC_ASSERT_SAME(a_led_only_on_close, clock, reset,
      step && (load_led || unload_led), win_close)
   `PFMC_ASSERT_NEXT(a_hits_clear_on_close, clock, reset,
      step && win_close, load_hits_ff == 4'd0 && unload_hits_ff == 4'd0)
   `PFMC_ASSERT_NEXT(a_hold_without_step, clock, reset,
      !step, load_state_ff == $past(load_state_ff) &&
      unload_state_ff == $past(unload_state_ff))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the paper feed motor controller.
// Depends on pfmc_pkg and paper_feed_motor_controller; a class predicts every
// result from the accepted ticks and the register settings.
`default_nettype none

module testbench;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PHASES = 10;
   localparam int TICKS_PER_PHASE = 60;

   class feed_checker;
      pfmc_pkg::cfg_type          cfg;
      logic [3:0]                 window_left, load_hits, unload_hits;
      logic [15:0]                load_pre_timer, unload_pre_timer;
      logic [15:0]                load_run_timer, unload_run_timer, watch_timer;
      pfmc_pkg::load_state_type   load_state;
      pfmc_pkg::unload_state_type unload_state;
      bit                         paper_missing;
      logic [7:0]                 retry_count;
      bit                         load_latch, unload_latch;
      pfmc_pkg::rsp_type          expected_outputs[$];
      int                         mismatches;

      function new();
         cfg = pfmc_pkg::CFG_RESET;
         window_left = pfmc_pkg::CFG_RESET.sample_window;
         load_hits = '0;
         unload_hits = '0;
         load_pre_timer = '0;
         unload_pre_timer = '0;
         load_run_timer = '0;
         unload_run_timer = '0;
         watch_timer = '0;
         load_state = pfmc_pkg::LS_IDLE;
         unload_state = pfmc_pkg::US_IDLE;
         paper_missing = 0;
         retry_count = '0;
         load_latch = 0;
         unload_latch = 0;
         mismatches = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            pfmc_pkg::REG_PRE_MOTOR_DELAY:   cfg.pre_motor_delay = value[15:0];
            pfmc_pkg::REG_LOAD_RUN_TIME:     cfg.load_run_time = value[15:0];
            pfmc_pkg::REG_UNLOAD_RUN_TIME:   cfg.unload_run_time = value[15:0];
            pfmc_pkg::REG_UNLOAD_WATCH_TIME: cfg.unload_watch_time = value[15:0];
            pfmc_pkg::REG_UNLOAD_PAUSE_TIME: cfg.unload_pause_time = value[15:0];
            pfmc_pkg::REG_SAMPLE_WINDOW:     cfg.sample_window = value[3:0];
            pfmc_pkg::REG_SAMPLE_THRESHOLD:  cfg.sample_threshold = value[3:0];
            default:                         cfg.retry_limit = value[7:0];
         endcase
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // Run start loads are one bit wider than a timer and clamp at its top.
      function logic [15:0] clamp_load(logic [16:0] v);
         return (v > 17'h0FFFF) ? 16'hFFFF : v[15:0];
      endfunction

      function void run_countdown(inout logic [15:0] timer, input logic [15:0] run_time,
                                  inout bit latch);
         if (timer != 0) begin
            timer = timer - 16'd1;
            if (timer >= run_time) begin
               latch = 1;
            end else if (timer <= 16'd1) begin
               latch = 0;
            end
         end
      endfunction

      function bit load_step(bit wanted);
         bit led;
         led = 0;
         case (load_state)
            pfmc_pkg::LS_IDLE: load_state = wanted ? pfmc_pkg::LS_ARM : pfmc_pkg::LS_DONE;
            pfmc_pkg::LS_ARM: begin
               load_pre_timer = cfg.pre_motor_delay;
               load_state = pfmc_pkg::LS_WAIT;
            end
            pfmc_pkg::LS_WAIT: begin
               if (load_pre_timer == 0) begin
                  load_run_timer = clamp_load({1'b0, cfg.load_run_time} + 17'd1);
                  led = 1;
                  load_state = pfmc_pkg::LS_CHECK;
               end
            end
            pfmc_pkg::LS_CHECK: begin
               load_state = wanted ? pfmc_pkg::LS_WAIT : pfmc_pkg::LS_DONE;
            end
            default: load_state = pfmc_pkg::LS_IDLE;
         endcase
         return led;
      endfunction

      function bit unload_step(bit wanted);
         bit led;
         led = 0;
         case (unload_state)
            pfmc_pkg::US_IDLE: begin
               if (wanted) begin
                  unload_state = pfmc_pkg::US_ARM;
               end else begin
                  paper_missing = 0;
                  unload_state = pfmc_pkg::US_DONE;
               end
            end
            pfmc_pkg::US_ARM: begin
               if (!paper_missing) begin
                  unload_pre_timer = cfg.pre_motor_delay;
                  unload_state = pfmc_pkg::US_PRE;
               end else begin
                  unload_state = pfmc_pkg::US_DONE;
               end
            end
            pfmc_pkg::US_PRE: begin
               if (unload_pre_timer == 0) begin
                  watch_timer = cfg.unload_watch_time;
                  unload_state = pfmc_pkg::US_START;
               end
            end
            pfmc_pkg::US_PAUSE: begin
               unload_pre_timer = cfg.unload_pause_time;
               unload_state = pfmc_pkg::US_START;
            end
            pfmc_pkg::US_START: begin
               if (unload_pre_timer == 0) begin
                  unload_run_timer = clamp_load({1'b0, cfg.unload_run_time} + 17'd2);
                  led = 1;
                  unload_state = pfmc_pkg::US_RUN;
               end
            end
            pfmc_pkg::US_RUN: begin
               if (unload_run_timer == 0) begin
                  unload_state = pfmc_pkg::US_CHECK;
               end
            end
            pfmc_pkg::US_CHECK: begin
               if (!wanted) begin
                  unload_state = pfmc_pkg::US_DONE;
               end else if (watch_timer == 0) begin
                  retry_count = retry_count + 8'd1;
                  paper_missing = 1;
                  if (retry_count >= cfg.retry_limit) begin
                     retry_count = '0;
                     unload_state = pfmc_pkg::US_DONE;
                  end else begin
                     unload_state = pfmc_pkg::US_PAUSE;
                  end
               end else begin
                  unload_state = pfmc_pkg::US_PAUSE;
               end
            end
            default: unload_state = pfmc_pkg::US_IDLE;
         endcase
         return led;
      endfunction

      function void note_tick(pfmc_pkg::req_type tick);
         pfmc_pkg::rsp_type outputs;
         bit                load_led, unload_led;
         load_led = 0;
         unload_led = 0;
         if (window_left != 0) begin
            window_left = window_left - 4'd1;
            if (tick.load_sensor && load_hits < pfmc_pkg::HITS_MAX) begin
               load_hits = load_hits + 4'd1;
            end
            if (!tick.unload_sensor && unload_hits < pfmc_pkg::HITS_MAX) begin
               unload_hits = unload_hits + 4'd1;
            end
         end
         if (unload_pre_timer != 0) unload_pre_timer = unload_pre_timer - 16'd1;
         if (load_pre_timer != 0) load_pre_timer = load_pre_timer - 16'd1;
         run_countdown(unload_run_timer, cfg.unload_run_time, unload_latch);
         run_countdown(load_run_timer, cfg.load_run_time, load_latch);
         if (watch_timer != 0) watch_timer = watch_timer - 16'd1;
         // Both sequencers step only on the tick that closes a window.
         if (window_left == 0) begin
            load_led = load_step(load_hits >= cfg.sample_threshold);
            unload_led = unload_step(unload_hits >= cfg.sample_threshold);
            load_hits = '0;
            unload_hits = '0;
            window_left = cfg.sample_window;
         end
         outputs.load_motor_on = load_latch;
         outputs.unload_motor_on = unload_latch;
         outputs.load_led_toggle = load_led;
         outputs.unload_led_toggle = unload_led;
         outputs.no_paper = paper_missing;
         expected_outputs.push_back(outputs);
      endfunction

      task compare_bit(string field, logic got, logic want);
         if (got !== want) begin
            report($sformatf("%s is %b, expected %b", field, got, want));
         end
      endtask

      task check_outputs(pfmc_pkg::rsp_type got);
         pfmc_pkg::rsp_type want;
         if (expected_outputs.size() == 0) begin
            report("result arrived with no tick outstanding");
         end else begin
            want = expected_outputs.pop_front();
            compare_bit("load_motor_on", got.load_motor_on, want.load_motor_on);
            compare_bit("unload_motor_on", got.unload_motor_on, want.unload_motor_on);
            compare_bit("load_led_toggle", got.load_led_toggle, want.load_led_toggle);
            compare_bit("unload_led_toggle", got.unload_led_toggle,
                        want.unload_led_toggle);
            compare_bit("no_paper", got.no_paper, want.no_paper);
         end
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   pfmc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   pfmc_pkg::rsp_type rsp_data;
   logic              psel = 0;
   logic              penable = 0;
   logic              pwrite = 0;
   logic [4:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   feed_checker board = new();
   bit          quiet = 0;
   int          stall_left = 0;
   int          cycles = 0;
   bit          load_level = 0;
   bit          unload_level = 1;

   paper_feed_motor_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Result side: take results and stall in bursts of random length.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_outputs(rsp_data);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left = idle_length();
         rsp_stall <= (stall_left > 0);
      end else begin
         rsp_stall <= 0;
      end
   end

   task send_tick(pfmc_pkg::req_type tick);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= tick;
      do @(posedge clock); while (req_stall);
      board.note_tick(tick);
   endtask

   // Sensor levels hold for stretches so that requests build up over windows.
   function pfmc_pkg::req_type next_tick();
      pfmc_pkg::req_type tick;
      if ($urandom_range(0, 99) < 8) load_level = !load_level;
      if ($urandom_range(0, 99) < 8) unload_level = !unload_level;
      tick.load_sensor = load_level ^ ($urandom_range(0, 19) == 0);
      tick.unload_sensor = unload_level ^ ($urandom_range(0, 19) == 0);
      return tick;
   endfunction

   function logic [31:0] reg_field(pfmc_pkg::cfg_type c, logic [2:0] idx);
      case (idx)
         pfmc_pkg::REG_PRE_MOTOR_DELAY:   return {16'd0, c.pre_motor_delay};
         pfmc_pkg::REG_LOAD_RUN_TIME:     return {16'd0, c.load_run_time};
         pfmc_pkg::REG_UNLOAD_RUN_TIME:   return {16'd0, c.unload_run_time};
         pfmc_pkg::REG_UNLOAD_WATCH_TIME: return {16'd0, c.unload_watch_time};
         pfmc_pkg::REG_UNLOAD_PAUSE_TIME: return {16'd0, c.unload_pause_time};
         pfmc_pkg::REG_SAMPLE_WINDOW:     return {28'd0, c.sample_window};
         pfmc_pkg::REG_SAMPLE_THRESHOLD:  return {28'd0, c.sample_threshold};
         default:                         return {24'd0, c.retry_limit};
      endcase
   endfunction

   task bus_access(logic write, logic [2:0] idx, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= write;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      if (!write && prdata !== reg_field(board.cfg, idx)) begin
         board.report($sformatf("register %0d reads %h, expected %h", idx, prdata,
                                reg_field(board.cfg, idx)));
      end
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   task apply_settings(pfmc_pkg::cfg_type c);
      logic [2:0] idx;
      for (int i = 0; i < 8; i++) begin
         idx = i[2:0];
         bus_access(1, idx, reg_field(c, idx));
         board.set_reg(idx, reg_field(c, idx));
         bus_access(0, idx, '0);
      end
   endtask

   task drain();
      req_valid <= 0;
      while (board.pending() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function pfmc_pkg::cfg_type settings_for(int phase);
      pfmc_pkg::cfg_type c;
      case (phase)
         0: c = '{16'd2, 16'd3, 16'd2, 16'd12, 16'd1, 4'd3, 4'd2, 8'd3};
         // Zero window, zero threshold, zero run times and zero retry limit.
         1: c = '{16'd1, 16'd0, 16'd0, 16'd5, 16'd0, 4'd0, 4'd0, 8'd0};
         2: c = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 4'd15, 4'd15, 8'd1};
         // Run time loads that overflow the timer and the widest registers.
         3: c = '{16'd1, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'd1, 4'd1, 8'd255};
         4: c = '{16'hFFFF, 16'hFFFD, 16'hFFFF, 16'd3, 16'd2, 4'd2, 4'd1, 8'd2};
         default: begin
            c.pre_motor_delay = 16'($urandom_range(0, 6));
            c.load_run_time = 16'($urandom_range(0, 6));
            c.unload_run_time = 16'($urandom_range(0, 6));
            c.unload_watch_time = 16'($urandom_range(0, 30));
            c.unload_pause_time = 16'($urandom_range(0, 4));
            c.sample_window = 4'($urandom_range(0, 5));
            c.sample_threshold = 4'($urandom_range(0, c.sample_window + 1));
            c.retry_limit = 8'($urandom_range(0, 4));
         end
      endcase
      return c;
   endfunction

   initial begin
      pfmc_pkg::req_type tick;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Every sensor combination at the default settings.
      quiet = 0;
      for (int i = 0; i < 16; i++) begin
         tick.load_sensor = i[0];
         tick.unload_sensor = i[1];
         send_tick(tick);
      end
      drain();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(settings_for(phase));
         quiet = ($urandom_range(0, 3) == 0);
         load_level = $urandom_range(0, 1);
         unload_level = $urandom_range(0, 1);
         for (int i = 0; i < TICKS_PER_PHASE; i++) send_tick(next_tick());
         drain();
      end
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
